[rtl/bfe_pkg.sv]
package bfe_pkg;

   localparam int MAX_BLOCK_DEFAULT = 256;
   localparam int FRAME_DEPTH = 5;
   localparam int FRAME_IDX_W = $clog2(FRAME_DEPTH);
   localparam int FRAME_CNT_W = $clog2(FRAME_DEPTH + 1);

   // Reply bytes, command markers and the erase quirk.
   localparam logic [7:0] ACK_BYTE = 8'h79;
   localparam logic [7:0] NACK_BYTE = 8'h1F;
   localparam logic [7:0] BUSY_BYTE = 8'h76;
   localparam logic [7:0] STD_ERASE = 8'h43;
   localparam logic [7:0] NO_CMD = 8'hFF;
   localparam logic [7:0] MASS_PAGES = 8'hFF;
   localparam logic [11:0] QUIRK_ID = 12'h416;
   localparam logic [7:0] QUIRK_PAGES = 8'hF8;

   // Request functions.
   localparam logic [2:0] FUNC_COMMAND = 3'd0;
   localparam logic [2:0] FUNC_WRITE_ADDR = 3'd1;
   localparam logic [2:0] FUNC_BLOCK_START = 3'd2;
   localparam logic [2:0] FUNC_DATA_BYTE = 3'd3;
   localparam logic [2:0] FUNC_ERASE_START = 3'd4;
   localparam logic [2:0] FUNC_ERASE_NEXT = 3'd5;
   localparam logic [2:0] FUNC_REPLY = 3'd6;

   // Result status codes.
   localparam logic [3:0] STATUS_OK = 4'd0;
   localparam logic [3:0] STATUS_ACK = 4'd1;
   localparam logic [3:0] STATUS_NACK = 4'd2;
   localparam logic [3:0] STATUS_BUSY = 4'd3;
   localparam logic [3:0] STATUS_UNEXPECTED = 4'd4;
   localparam logic [3:0] STATUS_MISALIGNED = 4'd5;
   localparam logic [3:0] STATUS_TOO_LONG = 4'd6;
   localparam logic [3:0] STATUS_NO_COMMAND = 4'd7;
   localparam logic [3:0] STATUS_OUT_OF_SEQ = 4'd8;

   // Configuration register indexes.
   localparam logic [1:0] REG_WRITE_OPCODE = 2'd0;
   localparam logic [1:0] REG_ERASE_OPCODE = 2'd1;
   localparam logic [1:0] REG_DEVICE_ID = 2'd2;

   typedef enum logic [3:0] {
      PHASE_IDLE  = 4'b0001,
      PHASE_ADDR  = 4'b0010,
      PHASE_DATA  = 4'b0100,
      PHASE_ERASE = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0]  write_opcode;
      logic [7:0]  erase_opcode;
      logic [11:0] device_id;
   } csr_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  opcode;
      logic [31:0] address;
      logic [8:0]  block_length;
      logic [7:0]  data_byte;
      logic [7:0]  start_page;
      logic [7:0]  page_count;
      logic [7:0]  reply_byte;
   } req_type;

   // All results of one request. Without transmit bytes there is exactly one
   // result that carries the status.
   typedef struct packed {
      logic [FRAME_DEPTH-1:0][7:0] data;
      logic [FRAME_CNT_W-1:0]      count;
      logic                        has_tx;
      logic [3:0]                  status;
   } frame_type;

endpackage

[rtl/bfe_req_if.sv]
interface bfe_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [7:0]  opcode;
   logic [31:0] address;
   logic [8:0]  block_length;
   logic [7:0]  data_byte;
   logic [7:0]  start_page;
   logic [7:0]  page_count;
   logic [7:0]  reply_byte;

   modport source (
      output valid, func, opcode, address, block_length, data_byte,
             start_page, page_count, reply_byte,
      input  ready
   );
   modport sink (
      input  valid, func, opcode, address, block_length, data_byte,
             start_page, page_count, reply_byte,
      output ready
   );
endinterface

[rtl/bfe_rsp_if.sv]
interface bfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_valid;
   logic       last;
   logic [3:0] status;

   modport source (
      output valid, tx_byte, tx_valid, last, status,
      input  ready
   );
   modport sink (
      input  valid, tx_byte, tx_valid, last, status,
      output ready
   );
endinterface

[rtl/bfe_csr.sv]
module bfe_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output bfe_pkg::csr_type  csr
);

   bfe_pkg::csr_type regs_ff;
   bfe_pkg::csr_type regs_in;
   logic             write_en;

   assign pready = 1'b1;
   assign write_en = psel && penable && pwrite;

   always_comb begin
      regs_in = regs_ff;
      if (write_en) begin
         case (paddr[3:2])
            bfe_pkg::REG_WRITE_OPCODE: regs_in.write_opcode = pwdata[7:0];
            bfe_pkg::REG_ERASE_OPCODE: regs_in.erase_opcode = pwdata[7:0];
            bfe_pkg::REG_DEVICE_ID:    regs_in.device_id = pwdata[11:0];
            default:                   regs_in = regs_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         bfe_pkg::REG_WRITE_OPCODE: prdata = {24'd0, regs_ff.write_opcode};
         bfe_pkg::REG_ERASE_OPCODE: prdata = {24'd0, regs_ff.erase_opcode};
         bfe_pkg::REG_DEVICE_ID:    prdata = {20'd0, regs_ff.device_id};
         default:                   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.write_opcode <= bfe_pkg::NO_CMD;
         regs_ff.erase_opcode <= bfe_pkg::NO_CMD;
         regs_ff.device_id <= 12'd0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr = regs_ff;

endmodule

[rtl/bfe_framer.sv]
module bfe_framer #(
   parameter int MAX_BLOCK = bfe_pkg::MAX_BLOCK_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   bfe_req_if.sink             req_bus,
   input  bfe_pkg::csr_type    csr,
   input  logic                sink_free,
   output logic                frame_valid,
   output bfe_pkg::frame_type  frame
);

   localparam int LEFT_W = $clog2(MAX_BLOCK + 1);
   localparam int PAGE_W = 9;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   bfe_pkg::req_type    s1_ff;
   logic                accept;
   logic                advance;

   logic [7:0]          running_xor_ff, running_xor_in;
   logic [LEFT_W-1:0]   bytes_left_ff, bytes_left_in;
   logic [PAGE_W-1:0]   next_page_ff, next_page_in;
   logic [7:0]          pages_left_ff, pages_left_in;
   bfe_pkg::phase_type  phase_ff, phase_in;
   logic                extended_ff, extended_in;

   logic [7:0]          addr_xor;
   logic [7:0]          pages_eff;
   logic [7:0]          page_hi;
   logic [7:0]          page_lo;
   logic [LEFT_W-1:0]   left_dec;
   logic [7:0]          pages_dec;
   logic [7:0]          data_xor;
   logic [7:0]          std_xor;
   logic [7:0]          ext_xor;

   bfe_pkg::frame_type  frame_c;

   assign advance = s1_valid_ff && ((frame_c.count == '0) || sink_free);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign accept = req_bus.valid && req_bus.ready;
   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   assign addr_xor = s1_ff.address[31:24] ^ s1_ff.address[23:16]
                   ^ s1_ff.address[15:8] ^ s1_ff.address[7:0];
   assign pages_eff = (csr.device_id == bfe_pkg::QUIRK_ID &&
                       s1_ff.page_count == bfe_pkg::MASS_PAGES) ?
                      bfe_pkg::QUIRK_PAGES : s1_ff.page_count;
   assign page_hi = {{(16 - PAGE_W){1'b0}}, next_page_ff[PAGE_W-1:8]};
   assign page_lo = next_page_ff[7:0];
   assign left_dec = bytes_left_ff - LEFT_W'(1);
   assign pages_dec = pages_left_ff - 8'd1;
   assign data_xor = running_xor_ff ^ s1_ff.data_byte;
   assign std_xor = running_xor_ff ^ page_lo;
   assign ext_xor = running_xor_ff ^ page_hi ^ page_lo;

   always_comb begin
      frame_c = '0;
      running_xor_in = running_xor_ff;
      bytes_left_in = bytes_left_ff;
      next_page_in = next_page_ff;
      pages_left_in = pages_left_ff;
      phase_in = phase_ff;
      extended_in = extended_ff;
      case (s1_ff.func)
         bfe_pkg::FUNC_COMMAND: begin
            frame_c.has_tx = 1'b1;
            frame_c.count = 3'd2;
            frame_c.data[0] = s1_ff.opcode;
            frame_c.data[1] = ~s1_ff.opcode;
         end
         bfe_pkg::FUNC_WRITE_ADDR: begin
            phase_in = bfe_pkg::PHASE_IDLE;
            frame_c.count = 3'd1;
            if (s1_ff.block_length == 9'd0) begin
               frame_c.status = bfe_pkg::STATUS_OK;
            end else if (s1_ff.block_length > 9'(MAX_BLOCK)) begin
               frame_c.status = bfe_pkg::STATUS_TOO_LONG;
            end else if (s1_ff.address[1:0] != 2'd0 ||
                         s1_ff.block_length[1:0] != 2'd0) begin
               frame_c.status = bfe_pkg::STATUS_MISALIGNED;
            end else if (csr.write_opcode == bfe_pkg::NO_CMD) begin
               frame_c.status = bfe_pkg::STATUS_NO_COMMAND;
            end else begin
               frame_c.has_tx = 1'b1;
               frame_c.count = 3'd5;
               frame_c.data[0] = s1_ff.address[31:24];
               frame_c.data[1] = s1_ff.address[23:16];
               frame_c.data[2] = s1_ff.address[15:8];
               frame_c.data[3] = s1_ff.address[7:0];
               frame_c.data[4] = addr_xor;
               bytes_left_in = LEFT_W'(s1_ff.block_length);
               phase_in = bfe_pkg::PHASE_ADDR;
            end
         end
         bfe_pkg::FUNC_BLOCK_START: begin
            frame_c.count = 3'd1;
            if (phase_ff != bfe_pkg::PHASE_ADDR) begin
               frame_c.status = bfe_pkg::STATUS_OUT_OF_SEQ;
            end else begin
               frame_c.has_tx = 1'b1;
               frame_c.data[0] = 8'(left_dec);
               running_xor_in = 8'(left_dec);
               phase_in = bfe_pkg::PHASE_DATA;
            end
         end
         bfe_pkg::FUNC_DATA_BYTE: begin
            frame_c.count = 3'd1;
            if (phase_ff != bfe_pkg::PHASE_DATA || bytes_left_ff == '0) begin
               frame_c.status = bfe_pkg::STATUS_OUT_OF_SEQ;
            end else begin
               frame_c.has_tx = 1'b1;
               frame_c.data[0] = s1_ff.data_byte;
               running_xor_in = data_xor;
               bytes_left_in = left_dec;
               if (left_dec == '0) begin
                  frame_c.count = 3'd2;
                  frame_c.data[1] = data_xor;
                  phase_in = bfe_pkg::PHASE_IDLE;
               end
            end
         end
         bfe_pkg::FUNC_ERASE_START: begin
            phase_in = bfe_pkg::PHASE_IDLE;
            frame_c.count = 3'd1;
            if (s1_ff.page_count == 8'd0) begin
               frame_c.status = bfe_pkg::STATUS_OK;
            end else if (csr.erase_opcode == bfe_pkg::NO_CMD) begin
               frame_c.status = bfe_pkg::STATUS_NO_COMMAND;
            end else if (csr.erase_opcode == bfe_pkg::STD_ERASE) begin
               extended_in = 1'b0;
               frame_c.has_tx = 1'b1;
               if (s1_ff.page_count == bfe_pkg::MASS_PAGES) begin
                  frame_c.count = 3'd2;
                  frame_c.data[0] = 8'hFF;
                  frame_c.data[1] = 8'h00;
               end else begin
                  frame_c.data[0] = s1_ff.page_count - 8'd1;
                  running_xor_in = s1_ff.page_count - 8'd1;
                  next_page_in = PAGE_W'(s1_ff.start_page);
                  pages_left_in = s1_ff.page_count;
                  phase_in = bfe_pkg::PHASE_ERASE;
               end
            end else begin
               extended_in = 1'b1;
               frame_c.has_tx = 1'b1;
               if (pages_eff == bfe_pkg::MASS_PAGES) begin
                  frame_c.count = 3'd3;
                  frame_c.data[0] = 8'hFF;
                  frame_c.data[1] = 8'hFF;
                  frame_c.data[2] = 8'h00;
               end else begin
                  frame_c.count = 3'd2;
                  frame_c.data[0] = 8'h00;
                  frame_c.data[1] = pages_eff - 8'd1;
                  running_xor_in = pages_eff - 8'd1;
                  next_page_in = PAGE_W'(s1_ff.start_page);
                  pages_left_in = pages_eff;
                  phase_in = bfe_pkg::PHASE_ERASE;
               end
            end
         end
         bfe_pkg::FUNC_ERASE_NEXT: begin
            frame_c.count = 3'd1;
            if (phase_ff != bfe_pkg::PHASE_ERASE || pages_left_ff == 8'd0) begin
               frame_c.status = bfe_pkg::STATUS_OUT_OF_SEQ;
            end else begin
               frame_c.has_tx = 1'b1;
               next_page_in = next_page_ff + PAGE_W'(1);
               pages_left_in = pages_dec;
               if (extended_ff) begin
                  frame_c.count = 3'd2;
                  frame_c.data[0] = page_hi;
                  frame_c.data[1] = page_lo;
                  frame_c.data[2] = ext_xor;
                  running_xor_in = ext_xor;
               end else begin
                  frame_c.data[0] = page_lo;
                  frame_c.data[1] = std_xor;
                  running_xor_in = std_xor;
               end
               // The checksum byte trails the last page.
               if (pages_dec == 8'd0) begin
                  frame_c.count = frame_c.count + 3'd1;
                  phase_in = bfe_pkg::PHASE_IDLE;
               end else begin
                  frame_c.data[2] = 8'h00;
                  if (!extended_ff) begin
                     frame_c.data[1] = 8'h00;
                  end
               end
            end
         end
         bfe_pkg::FUNC_REPLY: begin
            frame_c.count = 3'd1;
            if (s1_ff.reply_byte == bfe_pkg::ACK_BYTE) begin
               frame_c.status = bfe_pkg::STATUS_ACK;
            end else if (s1_ff.reply_byte == bfe_pkg::NACK_BYTE) begin
               frame_c.status = bfe_pkg::STATUS_NACK;
            end else if (s1_ff.reply_byte == bfe_pkg::BUSY_BYTE) begin
               frame_c.status = bfe_pkg::STATUS_BUSY;
            end else begin
               frame_c.status = bfe_pkg::STATUS_UNEXPECTED;
            end
         end
         default: begin
            frame_c = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         running_xor_ff <= 8'd0;
         bytes_left_ff <= '0;
         next_page_ff <= '0;
         pages_left_ff <= 8'd0;
         phase_ff <= bfe_pkg::PHASE_IDLE;
         extended_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            running_xor_ff <= running_xor_in;
            bytes_left_ff <= bytes_left_in;
            next_page_ff <= next_page_in;
            pages_left_ff <= pages_left_in;
            phase_ff <= phase_in;
            extended_ff <= extended_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff.func <= req_bus.func;
         s1_ff.opcode <= req_bus.opcode;
         s1_ff.address <= req_bus.address;
         s1_ff.block_length <= req_bus.block_length;
         s1_ff.data_byte <= req_bus.data_byte;
         s1_ff.start_page <= req_bus.start_page;
         s1_ff.page_count <= req_bus.page_count;
         s1_ff.reply_byte <= req_bus.reply_byte;
      end
   end

   assign frame_valid = s1_valid_ff && (frame_c.count != '0);
   assign frame = frame_c;

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == bfe_pkg::PHASE_DATA |-> bytes_left_ff != '0)
      else $error("data phase with no bytes left");

   a_erase_has_pages: assert property (@(posedge clock) disable iff (reset)
      phase_ff == bfe_pkg::PHASE_ERASE |-> pages_left_ff != 8'd0)
      else $error("erase phase with no pages left");

endmodule

[rtl/bfe_serializer.sv]
module bfe_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                frame_valid,
   input  bfe_pkg::frame_type  frame,
   output logic                sink_free,
   bfe_rsp_if.source           rsp_bus
);

   bfe_pkg::frame_type             frame_ff;
   logic                           valid_ff, valid_in;
   logic [bfe_pkg::FRAME_IDX_W-1:0] idx_ff, idx_in;
   logic                           is_last;
   logic                           taken;
   logic                           finishing;
   logic                           load;

   assign is_last = (bfe_pkg::FRAME_CNT_W'(idx_ff) == frame_ff.count - 1'b1);
   assign taken = valid_ff && rsp_bus.ready;
   assign finishing = taken && is_last;
   assign sink_free = !valid_ff || finishing;
   assign load = frame_valid && sink_free;

   always_comb begin
      valid_in = valid_ff;
      idx_in = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in = '0;
      end else if (finishing) begin
         valid_in = 1'b0;
         idx_in = '0;
      end else if (taken) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= frame;
      end
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.tx_byte = frame_ff.data[idx_ff];
   assign rsp_bus.tx_valid = frame_ff.has_tx;
   assign rsp_bus.last = is_last;
   assign rsp_bus.status = frame_ff.status;

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> bfe_pkg::FRAME_CNT_W'(idx_ff) < frame_ff.count)
      else $error("result index beyond frame");

   a_status_single: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !frame_ff.has_tx |-> frame_ff.count == 3'd1)
      else $error("status frame with more than one result");

endmodule

[rtl/bootloader_frame_encoder_unit.sv]
// A request is held in the input register, and its first result is presented once its frame
// is loaded into the output register. Throughput: one result per cycle while the receiver is
// ready; a request with n results (1 to 5) holds the output register until its last result is
// taken, and one more request is taken into the input register while results drain.
// A request that yields no result passes through the input register without waiting for the output register.
// Reset is synchronous and active high: link state goes idle, registers take
// their reset values, and no result is pending.
module bootloader_frame_encoder_unit #(
   parameter int MAX_BLOCK = bfe_pkg::MAX_BLOCK_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bfe_req_if.sink     req_bus,
   bfe_rsp_if.source   rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   bfe_pkg::csr_type   csr;
   bfe_pkg::frame_type frame;
   logic               frame_valid;
   logic               sink_free;

   bfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   bfe_framer #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_framer (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr         (csr),
      .sink_free   (sink_free),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   bfe_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame       (frame),
      .sink_free   (sink_free),
      .rsp_bus     (rsp_bus)
   );

endmodule

[test/tb_bootloader_frame_encoder_unit.sv]
`timescale 1ns / 100ps

module tb_bootloader_frame_encoder_unit;

   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_MAX = 10;
   localparam logic [2:0] FUNC_IGNORED = 3'd7;
   localparam logic [7:0] MASS_MARK = 8'hFF;
   localparam logic [7:0] MASS_END = 8'h00;
   localparam logic [7:0] EXT_COUNT_HI = 8'h00;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       last;
      logic [3:0] status;
   } link_out_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   bfe_req_if req_bus();
   bfe_rsp_if rsp_bus();

   bootloader_frame_encoder_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Register copies and link state of the encoder as the testbench sees it.
   logic [7:0]         cfg_write_opcode;
   logic [7:0]         cfg_erase_opcode;
   logic [11:0]        cfg_device_id;
   bfe_pkg::phase_type enc_phase;
   logic [7:0]         enc_xor;
   logic [8:0]         enc_left;
   logic [15:0]        enc_page;
   logic [7:0]         enc_pages_left;
   logic               enc_extended;

   link_out_type       expected_link_out[$];
   bfe_pkg::req_type   request_backlog[$];

   int req_offered = 0;
   int req_taken = 0;
   int rsp_taken = 0;
   int results_noted = 0;
   int req_gap = 0;
   int rsp_wait = 0;
   int long_stall_requests = 0;
   int long_stall_served = 0;
   int idle_cycles = 0;
   int error_count = 0;
   int settings_used = 0;
   int stimulus_items = 0;
   bit steady_sender = 1'b0;
   bit steady_receiver = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic link_out_type sent(logic [7:0] b);
      return '{b, 1'b1, 1'b0, bfe_pkg::STATUS_OK};
   endfunction

   function automatic link_out_type flagged(logic [3:0] st);
      return '{8'h00, 1'b0, 1'b0, st};
   endfunction

   function automatic string describe(link_out_type x);
      return $sformatf("byte %02h tx_valid %b last %b status %0d",
                       x.tx_byte, x.tx_valid, x.last, x.status);
   endfunction

   function automatic int draw_wait(bit steady);
      if (steady || $urandom_range(0, 2) == 0) begin
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   // Works out the bytes and statuses one request produces and advances the link state.
   task automatic encode_request(bfe_pkg::req_type r);
      link_out_type frame[$];
      logic [7:0] pages;
      pages = r.page_count;
      case (r.func)
         bfe_pkg::FUNC_COMMAND: begin
            frame.push_back(sent(r.opcode));
            frame.push_back(sent(~r.opcode));
         end
         bfe_pkg::FUNC_WRITE_ADDR: begin
            enc_phase = bfe_pkg::PHASE_IDLE;
            if (r.block_length == 0) begin
               frame.push_back(flagged(bfe_pkg::STATUS_OK));
            end else if (r.block_length > bfe_pkg::MAX_BLOCK_DEFAULT) begin
               frame.push_back(flagged(bfe_pkg::STATUS_TOO_LONG));
            end else if (r.address[1:0] != 2'b00 || r.block_length[1:0] != 2'b00) begin
               frame.push_back(flagged(bfe_pkg::STATUS_MISALIGNED));
            end else if (cfg_write_opcode == bfe_pkg::NO_CMD) begin
               frame.push_back(flagged(bfe_pkg::STATUS_NO_COMMAND));
            end else begin
               frame.push_back(sent(r.address[31:24]));
               frame.push_back(sent(r.address[23:16]));
               frame.push_back(sent(r.address[15:8]));
               frame.push_back(sent(r.address[7:0]));
               frame.push_back(sent(r.address[31:24] ^ r.address[23:16] ^
                                    r.address[15:8] ^ r.address[7:0]));
               enc_left = r.block_length;
               enc_phase = bfe_pkg::PHASE_ADDR;
            end
         end
         bfe_pkg::FUNC_BLOCK_START: begin
            if (enc_phase != bfe_pkg::PHASE_ADDR) begin
               frame.push_back(flagged(bfe_pkg::STATUS_OUT_OF_SEQ));
            end else begin
               enc_xor = 8'(enc_left - 9'd1);
               frame.push_back(sent(enc_xor));
               enc_phase = bfe_pkg::PHASE_DATA;
            end
         end
         bfe_pkg::FUNC_DATA_BYTE: begin
            if (enc_phase != bfe_pkg::PHASE_DATA || enc_left == 0) begin
               frame.push_back(flagged(bfe_pkg::STATUS_OUT_OF_SEQ));
            end else begin
               enc_xor = enc_xor ^ r.data_byte;
               frame.push_back(sent(r.data_byte));
               enc_left = enc_left - 9'd1;
               if (enc_left == 0) begin
                  frame.push_back(sent(enc_xor));
                  enc_phase = bfe_pkg::PHASE_IDLE;
               end
            end
         end
         bfe_pkg::FUNC_ERASE_START: begin
            enc_phase = bfe_pkg::PHASE_IDLE;
            if (pages == 0) begin
               frame.push_back(flagged(bfe_pkg::STATUS_OK));
            end else if (cfg_erase_opcode == bfe_pkg::NO_CMD) begin
               frame.push_back(flagged(bfe_pkg::STATUS_NO_COMMAND));
            end else if (cfg_erase_opcode == bfe_pkg::STD_ERASE) begin
               enc_extended = 1'b0;
               if (pages == bfe_pkg::MASS_PAGES) begin
                  frame.push_back(sent(MASS_MARK));
                  frame.push_back(sent(MASS_END));
               end else begin
                  enc_xor = pages - 8'd1;
                  frame.push_back(sent(enc_xor));
                  enc_page = {8'h00, r.start_page};
                  enc_pages_left = pages;
                  enc_phase = bfe_pkg::PHASE_ERASE;
               end
            end else begin
               enc_extended = 1'b1;
               // This product cannot mass erase; it gets an explicit list instead.
               if (cfg_device_id == bfe_pkg::QUIRK_ID && pages == bfe_pkg::MASS_PAGES) begin
                  pages = bfe_pkg::QUIRK_PAGES;
               end
               if (pages == bfe_pkg::MASS_PAGES) begin
                  frame.push_back(sent(MASS_MARK));
                  frame.push_back(sent(MASS_MARK));
                  frame.push_back(sent(MASS_END));
               end else begin
                  enc_xor = pages - 8'd1;
                  frame.push_back(sent(EXT_COUNT_HI));
                  frame.push_back(sent(enc_xor));
                  enc_page = {8'h00, r.start_page};
                  enc_pages_left = pages;
                  enc_phase = bfe_pkg::PHASE_ERASE;
               end
            end
         end
         bfe_pkg::FUNC_ERASE_NEXT: begin
            if (enc_phase != bfe_pkg::PHASE_ERASE || enc_pages_left == 0) begin
               frame.push_back(flagged(bfe_pkg::STATUS_OUT_OF_SEQ));
            end else begin
               if (enc_extended) begin
                  enc_xor = enc_xor ^ enc_page[15:8] ^ enc_page[7:0];
                  frame.push_back(sent(enc_page[15:8]));
                  frame.push_back(sent(enc_page[7:0]));
               end else begin
                  enc_xor = enc_xor ^ enc_page[7:0];
                  frame.push_back(sent(enc_page[7:0]));
               end
               enc_page = enc_page + 16'd1;
               enc_pages_left = enc_pages_left - 8'd1;
               if (enc_pages_left == 0) begin
                  frame.push_back(sent(enc_xor));
                  enc_phase = bfe_pkg::PHASE_IDLE;
               end
            end
         end
         bfe_pkg::FUNC_REPLY: begin
            case (r.reply_byte)
               bfe_pkg::ACK_BYTE: frame.push_back(flagged(bfe_pkg::STATUS_ACK));
               bfe_pkg::NACK_BYTE: frame.push_back(flagged(bfe_pkg::STATUS_NACK));
               bfe_pkg::BUSY_BYTE: frame.push_back(flagged(bfe_pkg::STATUS_BUSY));
               default: frame.push_back(flagged(bfe_pkg::STATUS_UNEXPECTED));
            endcase
         end
         default: begin
         end
      endcase
      if (frame.size() > 0) begin
         frame[frame.size() - 1].last = 1'b1;
      end
      foreach (frame[i]) begin
         expected_link_out.push_back(frame[i]);
      end
   endtask

   function automatic bfe_pkg::req_type make_request(logic [2:0] f);
      bfe_pkg::req_type r;
      r.func = f;
      r.opcode = 8'($urandom);
      r.address = $urandom;
      r.block_length = 9'($urandom);
      r.data_byte = 8'($urandom);
      r.start_page = 8'($urandom);
      r.page_count = 8'($urandom);
      r.reply_byte = 8'($urandom);
      return r;
   endfunction

   task automatic offer(bfe_pkg::req_type r);
      request_backlog.push_back(r);
      if (r.func != FUNC_IGNORED) begin
         stimulus_items++;
      end
   endtask

   task automatic settle();
      while (request_backlog.size() != 0 || req_bus.valid || expected_link_out.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         bfe_pkg::REG_WRITE_OPCODE: cfg_write_opcode = value[7:0];
         bfe_pkg::REG_ERASE_OPCODE: cfg_erase_opcode = value[7:0];
         bfe_pkg::REG_DEVICE_ID: cfg_device_id = value[11:0];
         default: begin
         end
      endcase
   endtask

   task automatic apply_setting(logic [7:0] wop, logic [7:0] eop, logic [11:0] id);
      settle();
      write_register(bfe_pkg::REG_WRITE_OPCODE, {24'h0, wop});
      write_register(bfe_pkg::REG_ERASE_OPCODE, {24'h0, eop});
      write_register(bfe_pkg::REG_DEVICE_ID, {20'h0, id});
      settings_used++;
      @(posedge clock);
   endtask

   // Mostly complete write and erase transactions with random content, plus
   // truncated transactions, stray requests and plain noise. A transaction that
   // would run past the request budget is cut short there.
   task automatic queue_random_traffic(int count);
      int target;
      int n;
      bit broken;
      bfe_pkg::req_type r;
      target = stimulus_items + count;
      while (stimulus_items < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               r = make_request(bfe_pkg::FUNC_WRITE_ADDR);
               r.address[1:0] = 2'b00;
               r.block_length = ($urandom_range(0, 11) == 0) ? 9'd256
                                : 9'(4 * $urandom_range(1, 8));
               broken = ($urandom_range(0, 7) == 0);
               if (broken) begin
                  if ($urandom_range(0, 1) == 0) begin
                     r.block_length = r.block_length + 9'($urandom_range(1, 3));
                  end else begin
                     r.address[1:0] = 2'($urandom_range(1, 3));
                  end
               end
               offer(r);
               n = broken ? $urandom_range(0, 3) : int'(r.block_length);
               if ($urandom_range(0, 9) == 0) begin
                  n = $urandom_range(0, n);
               end
               if ($urandom_range(0, 15) != 0) begin
                  offer(make_request(bfe_pkg::FUNC_BLOCK_START));
               end
               for (int i = 0; i < n && stimulus_items < target; i++) begin
                  offer(make_request(bfe_pkg::FUNC_DATA_BYTE));
               end
               if ($urandom_range(0, 9) == 0) begin
                  offer(make_request(bfe_pkg::FUNC_DATA_BYTE));
               end
            end
            4, 5, 6: begin
               r = make_request(bfe_pkg::FUNC_ERASE_START);
               case ($urandom_range(0, 5))
                  0: r.page_count = bfe_pkg::MASS_PAGES;
                  1: r.page_count = 8'($urandom_range(7, 254));
                  default: r.page_count = 8'($urandom_range(1, 6));
               endcase
               if ($urandom_range(0, 3) == 0) begin
                  r.start_page = 8'($urandom_range(250, 255));
               end
               offer(r);
               n = (r.page_count == bfe_pkg::MASS_PAGES) ? 3 : int'(r.page_count);
               // Long lists are cut short and left for the next request to abort.
               if (n > 10) begin
                  n = $urandom_range(2, 10);
               end
               if ($urandom_range(0, 7) == 0) begin
                  n = $urandom_range(0, n + 1);
               end
               for (int i = 0; i < n && stimulus_items < target; i++) begin
                  offer(make_request(bfe_pkg::FUNC_ERASE_NEXT));
               end
            end
            7: offer(make_request(bfe_pkg::FUNC_COMMAND));
            8: begin
               r = make_request(bfe_pkg::FUNC_REPLY);
               case ($urandom_range(0, 3))
                  0: r.reply_byte = bfe_pkg::ACK_BYTE;
                  1: r.reply_byte = bfe_pkg::NACK_BYTE;
                  2: r.reply_byte = bfe_pkg::BUSY_BYTE;
                  default: begin
                  end
               endcase
               offer(r);
            end
            default: offer(make_request(3'($urandom_range(0, 7))));
         endcase
      end
   endtask

   task automatic run_phase(logic [7:0] wop, logic [7:0] eop, logic [11:0] id, int count,
                            bit steady_tx, bit steady_rx, bit long_hold);
      apply_setting(wop, eop, id);
      steady_sender = steady_tx;
      steady_receiver = steady_rx;
      queue_random_traffic(count);
      if (long_hold) begin
         long_stall_requests++;
      end
   endtask

   // Request driver: offers one request at a time from the backlog.
   always @(negedge clock) begin : request_driver
      bfe_pkg::req_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken == req_offered) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (request_backlog.size() != 0) begin
            item = request_backlog.pop_front();
            req_bus.func <= item.func;
            req_bus.opcode <= item.opcode;
            req_bus.address <= item.address;
            req_bus.block_length <= item.block_length;
            req_bus.data_byte <= item.data_byte;
            req_bus.start_page <= item.start_page;
            req_bus.page_count <= item.page_count;
            req_bus.reply_byte <= item.reply_byte;
            req_bus.valid <= 1'b1;
            req_offered <= req_offered + 1;
            req_gap <= draw_wait(steady_sender);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result receiver: random waits after each result, and a long hold-off on demand.
   always @(negedge clock) begin : result_receiver
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (long_stall_served != long_stall_requests) begin
            long_stall_served = long_stall_requests;
            results_noted = rsp_taken;
            rsp_wait = LONG_HOLD;
         end else if (rsp_taken != results_noted) begin
            results_noted = rsp_taken;
            rsp_wait = draw_wait(steady_receiver);
         end else if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
         end
         rsp_bus.ready <= (rsp_wait == 0);
      end
   end

   always @(posedge clock) begin : link_monitor
      link_out_type seen;
      link_out_type want;
      bfe_pkg::req_type r;
      if (reset) begin
         enc_phase = bfe_pkg::PHASE_IDLE;
         enc_xor = 8'h00;
         enc_left = 9'd0;
         enc_page = 16'd0;
         enc_pages_left = 8'd0;
         enc_extended = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = '{rsp_bus.tx_byte, rsp_bus.tx_valid, rsp_bus.last, rsp_bus.status};
            rsp_taken = rsp_taken + 1;
            if (expected_link_out.size() == 0) begin
               report_error({"result with none expected: ", describe(seen)});
            end else begin
               want = expected_link_out.pop_front();
               if (seen.tx_byte !== want.tx_byte || seen.tx_valid !== want.tx_valid ||
                   seen.last !== want.last || seen.status !== want.status) begin
                  report_error({"expected ", describe(want), ", got ", describe(seen)});
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            r = '{req_bus.func, req_bus.opcode, req_bus.address, req_bus.block_length,
                  req_bus.data_byte, req_bus.start_page, req_bus.page_count,
                  req_bus.reply_byte};
            encode_request(r);
            req_taken = req_taken + 1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("No request or result moved for %0d cycles.", IDLE_LIMIT);
         $display("bootloader_frame_encoder_unit: mismatch");
         $finish;
      end
   end

   initial begin
      bfe_pkg::req_type r;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 4'h0;
      pwdata = 32'h0;
      req_bus.valid = 1'b0;
      req_bus.func = bfe_pkg::FUNC_COMMAND;
      req_bus.opcode = 8'h00;
      req_bus.address = 32'h0;
      req_bus.block_length = 9'h0;
      req_bus.data_byte = 8'h00;
      req_bus.start_page = 8'h00;
      req_bus.page_count = 8'h00;
      req_bus.reply_byte = 8'h00;
      rsp_bus.ready = 1'b0;
      cfg_write_opcode = bfe_pkg::NO_CMD;
      cfg_erase_opcode = bfe_pkg::NO_CMD;
      cfg_device_id = 12'h000;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: no write or erase command is offered yet.
      r = make_request(bfe_pkg::FUNC_COMMAND); r.opcode = 8'h00; offer(r);
      r = make_request(bfe_pkg::FUNC_COMMAND); r.opcode = 8'hFF; offer(r);
      r = make_request(bfe_pkg::FUNC_WRITE_ADDR); r.block_length = 9'd0; offer(r);
      r = make_request(bfe_pkg::FUNC_WRITE_ADDR); r.block_length = 9'h1FF; offer(r);
      r = make_request(bfe_pkg::FUNC_WRITE_ADDR); r.address = 32'h2; r.block_length = 9'd8;
      offer(r);
      r = make_request(bfe_pkg::FUNC_WRITE_ADDR); r.address = 32'h0; r.block_length = 9'd4;
      offer(r);
      offer(make_request(bfe_pkg::FUNC_BLOCK_START));
      offer(make_request(bfe_pkg::FUNC_DATA_BYTE));
      offer(make_request(bfe_pkg::FUNC_ERASE_NEXT));
      r = make_request(bfe_pkg::FUNC_ERASE_START); r.page_count = 8'd0; offer(r);
      r = make_request(bfe_pkg::FUNC_ERASE_START); r.page_count = 8'd5; offer(r);
      r = make_request(bfe_pkg::FUNC_REPLY); r.reply_byte = bfe_pkg::ACK_BYTE; offer(r);
      r = make_request(bfe_pkg::FUNC_REPLY); r.reply_byte = bfe_pkg::NACK_BYTE; offer(r);
      r = make_request(bfe_pkg::FUNC_REPLY); r.reply_byte = bfe_pkg::BUSY_BYTE; offer(r);
      r = make_request(bfe_pkg::FUNC_REPLY); r.reply_byte = 8'h00; offer(r);
      offer(make_request(FUNC_IGNORED));

      // Standard erase: a full write at the top of memory, mass erase, and a
      // page list that wraps past page 255.
      apply_setting(8'h31, bfe_pkg::STD_ERASE, 12'h000);
      r = make_request(bfe_pkg::FUNC_WRITE_ADDR);
      r.address = 32'hFFFF_FFFC;
      r.block_length = 9'd4;
      offer(r);
      offer(make_request(bfe_pkg::FUNC_BLOCK_START));
      r = make_request(bfe_pkg::FUNC_DATA_BYTE); r.data_byte = 8'hFF; offer(r);
      r = make_request(bfe_pkg::FUNC_DATA_BYTE); r.data_byte = 8'h00; offer(r);
      r = make_request(bfe_pkg::FUNC_DATA_BYTE); r.data_byte = 8'hA5; offer(r);
      r = make_request(bfe_pkg::FUNC_DATA_BYTE); r.data_byte = 8'h5A; offer(r);
      r = make_request(bfe_pkg::FUNC_ERASE_START); r.page_count = bfe_pkg::MASS_PAGES;
      offer(r);
      r = make_request(bfe_pkg::FUNC_ERASE_START); r.start_page = 8'd255;
      r.page_count = 8'd2;
      offer(r);
      offer(make_request(bfe_pkg::FUNC_ERASE_NEXT));
      offer(make_request(bfe_pkg::FUNC_ERASE_NEXT));

      run_phase(8'h12, bfe_pkg::STD_ERASE, bfe_pkg::QUIRK_ID, 49, 1'b0, 1'b0, 1'b0);
      run_phase(8'h44, 8'h44, bfe_pkg::QUIRK_ID, 49, 1'b1, 1'b0, 1'b1);
      run_phase(8'h00, 8'h00, 12'hFFF, 49, 1'b0, 1'b0, 1'b0);
      run_phase(bfe_pkg::NO_CMD, bfe_pkg::STD_ERASE, 12'h415, 49, 1'b0, 1'b1, 1'b0);
      run_phase(8'hFE, 8'hFE, bfe_pkg::QUIRK_ID, 49, 1'b1, 1'b1, 1'b0);
      run_phase(8'h31, bfe_pkg::NO_CMD, bfe_pkg::QUIRK_ID, 49, 1'b0, 1'b0, 1'b0);
      run_phase(8'($urandom), 8'($urandom), 12'($urandom), 49, 1'b0, 1'b0, 1'b1);
      settle();

      if (expected_link_out.size() != 0) begin
         report_error($sformatf("%0d expected results never arrived",
                                expected_link_out.size()));
      end
      $display("Checked %0d results from %0d requests over %0d register settings,",
               rsp_taken, req_taken, settings_used);
      $display("covering commands, writes, erases and replies with random stalls; %0d errors.",
               error_count);
      if (error_count == 0) begin
         $display("bootloader_frame_encoder_unit: match");
      end else begin
         $display("bootloader_frame_encoder_unit: mismatch");
      end
      $finish;
   end

endmodule
